// ----- hdl/lpr_pkg.sv -----
// Shared types and constants for the linear parameter ramp.
// Holds item structs, action codes, controller state and command types.
// No dependencies.
package lpr_pkg;

  // Formats: values Q16.16, accumulator and step Q32.16
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned FRAC_SHIFT = 16;
  localparam int unsigned ACC_W      = VAL_W + FRAC_SHIFT;
  localparam int unsigned CFG_W      = 16;

  // Serial divider: magnitude of a 49-bit difference, one quotient bit a cycle
  localparam int unsigned DIV_BITS = ACC_W + 1;
  localparam int unsigned CNT_W    = $clog2(DIV_BITS);

  // Shortest ramp accepted; shorter writes are clamped up
  localparam logic [CFG_W-1:0] MIN_RAMP_SAMPLES = 16'd1;

  // Configuration register indexes
  localparam logic CFG_RAMP_SAMPLES = 1'b0;
  localparam logic CFG_MIN_DELTA    = 1'b1;

  // Item actions; the fourth code leaves the ramp state unchanged
  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_SET  = 2'd1,
    ACT_SKIP = 2'd2
  } action_e;

  typedef struct packed {
    logic [1:0]              action;
    logic signed [VAL_W-1:0] target_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] current_value;
    logic                    ramping;
  } out_item_t;

  // Controller states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_PREP   = 4'b0010,
    ST_DIV    = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic commit;
  } lpr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_set;
    logic div_last;
    logic out_free;
  } lpr_status_t;

endpackage

// ----- hdl/lpr_ctrl.sv -----
// Controller for the linear parameter ramp: sequences accept, prepare,
// divide and commit steps of one item. Depends on lpr_pkg.
module lpr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lpr_pkg::lpr_status_t status_i,
  output lpr_pkg::lpr_cmd_t    cmd_o
);
  import lpr_pkg::*;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = status_i.is_set ? ST_DIV : ST_FINISH;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A result is only committed into a free output slot
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> status_i.out_free)
    else $error("commit into occupied output slot");

  // An accepted item always goes to the prepare step next
  a_load_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_PREP))
    else $error("accepted item did not reach prepare");

endmodule

// ----- hdl/lpr_dp.sv -----
// Datapath for the linear parameter ramp: config registers, ramp state,
// serial divider and output register. Depends on lpr_pkg.
module lpr_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lpr_pkg::in_item_t          in_data_i,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [lpr_pkg::CFG_W-1:0]  cfg_data_i,
  input  lpr_pkg::lpr_cmd_t          cmd_i,
  output lpr_pkg::lpr_status_t       status_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output lpr_pkg::out_item_t         out_data_o
);
  import lpr_pkg::*;

  // Configuration
  logic [CFG_W-1:0] rs_q, md_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_q <= 16'd1;
      md_q <= 16'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RAMP_SAMPLES: rs_q <= (cfg_data_i < MIN_RAMP_SAMPLES) ? MIN_RAMP_SAMPLES
                                                                  : cfg_data_i;
        CFG_MIN_DELTA:    md_q <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  // Ramp state
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [VAL_W-1:0] tgt_q, tgt_d;
  logic [ACC_W-1:0] step_q, step_d;

  // Latched item
  logic [1:0]       act_q;
  logic [VAL_W-1:0] in_tgt_q;

  // Prepared operands
  logic [DIV_BITS-1:0] mag_q;
  logic                neg_q;
  logic [ACC_W-1:0]    smag_q;
  logic                cur_ramp_q;

  // Divider
  logic [DIV_BITS-1:0] quo_q;
  logic [CFG_W-1:0]    rem_q;
  logic [CNT_W-1:0]    cnt_q;

  // Output register
  logic      out_valid_q;
  out_item_t out_data_q, out_data_d;

  // Difference against the chosen target and step magnitude
  logic [VAL_W-1:0]    sel_tgt;
  logic [ACC_W-1:0]    sel_wide;
  logic [DIV_BITS-1:0] diff;
  logic [DIV_BITS-1:0] diff_mag;
  logic [ACC_W-1:0]    step_mag;

  always_comb begin
    sel_tgt  = (act_q == ACT_TICK) ? tgt_q : in_tgt_q;
    sel_wide = {sel_tgt, {FRAC_SHIFT{1'b0}}};
    diff     = {sel_wide[ACC_W-1], sel_wide} - {acc_q[ACC_W-1], acc_q};
    diff_mag = diff[DIV_BITS-1] ? (~diff + 1'b1) : diff;
    step_mag = step_q[ACC_W-1] ? (~step_q + 1'b1) : step_q;
  end

  // One restoring division step
  logic [CFG_W:0] rem_sh;
  logic           rem_ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[DIV_BITS-1]};
    rem_ge = (rem_sh >= {1'b0, rs_q});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q    <= in_data_i.action;
      in_tgt_q <= in_data_i.target_value;
    end
    if (cmd_i.prep) begin
      mag_q      <= diff_mag;
      neg_q      <= diff[DIV_BITS-1];
      smag_q     <= step_mag;
      cur_ramp_q <= (acc_q != {tgt_q, {FRAC_SHIFT{1'b0}}});
      quo_q      <= diff_mag;
      rem_q      <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[DIV_BITS-2:0], rem_ge};
      rem_q <= rem_ge ? CFG_W'(rem_sh - {1'b0, rs_q}) : rem_sh[CFG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.prep) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // Signed, saturated quotient
  logic [ACC_W-1:0] q_sat;
  logic             pos_ovf, neg_ovf;

  always_comb begin
    pos_ovf = quo_q[DIV_BITS-1] | quo_q[DIV_BITS-2];
    neg_ovf = quo_q[DIV_BITS-1] | (quo_q[DIV_BITS-2] & (|quo_q[DIV_BITS-3:0]));
    if (!neg_q) begin
      q_sat = pos_ovf ? {1'b0, {(ACC_W-1){1'b1}}} : quo_q[ACC_W-1:0];
    end else begin
      q_sat = neg_ovf ? {1'b1, {(ACC_W-1){1'b0}}} : ACC_W'(~quo_q + 1'b1);
    end
  end

  // State update and result of the item
  logic tick_go, upd;
  logic [ACC_W-1:0] md_wide;

  always_comb begin
    md_wide  = {{(ACC_W-CFG_W-FRAC_SHIFT){1'b0}}, md_q, {FRAC_SHIFT{1'b0}}};
    tick_go  = (mag_q > {smag_q, 1'b0}) && (smag_q > md_wide);
    upd      = (mag_q > {1'b0, md_wide});
    acc_d    = acc_q;
    tgt_d    = tgt_q;
    step_d   = step_q;
    out_data_d.ramping = cur_ramp_q;
    case (act_q)
      ACT_TICK: begin
        acc_d = tick_go ? (acc_q + step_q) : {tgt_q, {FRAC_SHIFT{1'b0}}};
        out_data_d.ramping = tick_go;
      end
      ACT_SET, ACT_SKIP: begin
        if (upd) begin
          tgt_d  = in_tgt_q;
          step_d = q_sat;
          out_data_d.ramping = 1'b1;
        end
        if (act_q == ACT_SKIP) begin
          tgt_d = in_tgt_q;
          acc_d = {in_tgt_q, {FRAC_SHIFT{1'b0}}};
          out_data_d.ramping = 1'b0;
        end
      end
      default: ;
    endcase
    out_data_d.current_value = acc_d[ACC_W-1:FRAC_SHIFT];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      tgt_q  <= '0;
      step_q <= '0;
    end else if (cmd_i.commit) begin
      acc_q  <= acc_d;
      tgt_q  <= tgt_d;
      step_q <= step_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    status_o.is_set   = 1'b0;
    case (act_q) inside
      ACT_SET, ACT_SKIP: status_o.is_set = 1'b1;
      default:           status_o.is_set = 1'b0;
    endcase
    status_o.div_last = (cnt_q == CNT_W'(DIV_BITS - 1));
    status_o.out_free = !out_valid_q || !out_stall_i;
  end

  // Divider never runs past its last quotient bit
  a_div_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (cnt_q < CNT_W'(DIV_BITS)))
    else $error("divider stepped past last bit");

  // A committed item shows up as a valid result
  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("committed item not presented");

  // Ramp state only moves on commit
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.commit |=> $stable(acc_q) && $stable(tgt_q) && $stable(step_q))
    else $error("ramp state changed without commit");

endmodule

// ----- hdl/linear_parameter_ramp.sv -----
// Linear parameter ramp top level: joins controller and datapath.
// Depends on lpr_pkg, lpr_ctrl and lpr_dp.
//
// Each item is taken when the block is idle and gives one result. A tick
// (or the unused fourth action code) passes the prepare and finish states
// to the result register; a set-target item, with or without skip, also
// passes the divide state, where the serial divider forms the per-tick
// step one quotient bit per cycle over a 49-bit distance. The next item
// is taken the cycle after a result is registered, even while that result
// still waits downstream; a second result waits in the finish state until
// the output register frees. Configuration must be written only while
// idle; the block itself does not enforce this. A ramp length below the
// minimum is stored as the minimum.
module linear_parameter_ramp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  lpr_pkg::in_item_t         in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output lpr_pkg::out_item_t        out_data_o,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [lpr_pkg::CFG_W-1:0] cfg_data_i
);
  import lpr_pkg::*;

  lpr_cmd_t    cmd;
  lpr_status_t status;

  lpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lpr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
